### rtl/character_range_expander_macros.svh
// ----------------------------------------------------------------------------
// character_range_expander_macros
// Assertion macros shared by the checker of the range expander.
// ----------------------------------------------------------------------------
`ifndef CHARACTER_RANGE_EXPANDER_MACROS_SVH
`define CHARACTER_RANGE_EXPANDER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CRE_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define CRE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/cre_pkg.sv
// ----------------------------------------------------------------------------
// cre_pkg
// Types, constants and helpers shared by the range expander modules.
// ----------------------------------------------------------------------------
`default_nettype none

package cre_pkg;

	localparam logic [7:0] CHAR_HYPHEN = 8'h2D;
	localparam logic [7:0] CHAR_LOWER_A = 8'h61;
	localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
	localparam logic [7:0] CHAR_UPPER_A = 8'h41;
	localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
	localparam logic [7:0] CHAR_DIGIT_0 = 8'h30;
	localparam logic [7:0] CHAR_DIGIT_9 = 8'h39;
	localparam logic [7:0] CHAR_NUL = 8'h00;

	// Default depth of the command queue between front and back.
	localparam int QUEUE_DEPTH = 2;

	typedef enum logic [1:0] {
		CLS_NONE,
		CLS_LOWER,
		CLS_UPPER,
		CLS_DIGIT
	} cls_t;

	typedef enum logic [1:0] {
		B_IDLE,
		B_RANGE,
		B_LAST
	} back_phase_t;

	// One command word: an optional run rng_lo..rng_hi, then an optional
	// single result (character, hyphen or empty marker).
	typedef struct packed {
		logic       rng_v;
		logic [7:0] rng_lo;
		logic [7:0] rng_hi;
		logic       last_v;
		logic [7:0] last_char;
		logic       last_present;
		logic       eol;
	} cmd_t;

	function automatic cls_t char_class(input logic [7:0] c);
		cls_t r;
		r = CLS_NONE;
		if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z) begin
			r = CLS_LOWER;
		end else if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) begin
			r = CLS_UPPER;
		end else if (c >= CHAR_DIGIT_0 && c <= CHAR_DIGIT_9) begin
			r = CLS_DIGIT;
		end
		return r;
	endfunction

endpackage

`default_nettype wire

### rtl/cre_queue.sv
// ----------------------------------------------------------------------------
// cre_queue
// Short register queue of command words between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module cre_queue
	import cre_pkg::*;
#(
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic wr,
	input  wire cmd_t wr_data,
	output logic      full,
	input  wire logic rd,
	output cmd_t      rd_data,
	output logic      empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST_IDX = PW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	cmd_t          mem_q [DEPTH];
	logic [PW-1:0] wptr_q;
	logic [PW-1:0] rptr_q;
	logic [CW-1:0] cnt_q;
	logic          do_wr;
	logic          do_rd;

	assign full    = (cnt_q == FULL_CNT);
	assign empty   = (cnt_q == '0);
	assign do_wr   = wr && !full;
	assign do_rd   = rd && !empty;
	assign rd_data = mem_q[rptr_q];

	// Store the incoming word
	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wptr_q] <= wr_data;
		end
	end

	// Advance pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (do_wr) begin
				wptr_q <= (wptr_q == LAST_IDX) ? '0 : wptr_q + PW'(1);
			end
			if (do_rd) begin
				rptr_q <= (rptr_q == LAST_IDX) ? '0 : rptr_q + PW'(1);
			end
			if (do_wr && !do_rd) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (do_rd && !do_wr) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

endmodule

`default_nettype wire

### rtl/cre_front.sv
// ----------------------------------------------------------------------------
// cre_front
// Accepts characters, tracks hyphen state and classifies each character into
// a command word for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module cre_front
	import cre_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       push,
	input  wire logic [7:0] in_char,
	input  wire logic       end_of_line,
	input  wire logic       q_full,
	output logic            full,
	output logic            q_wr,
	output cmd_t            q_data
);

	logic [7:0] prev_q;
	logic       pend_q;
	logic [7:0] cbh_q;

	logic       accept;
	logic       is_hyphen;
	cls_t       cls_c;
	cls_t       cls_b;
	cls_t       cls_p;
	logic [7:0] cbh_next;

	assign full      = q_full;
	assign accept    = push && !q_full;
	assign is_hyphen = (in_char == CHAR_HYPHEN);
	assign cls_c     = char_class(in_char);
	assign cls_b     = char_class(cbh_q);
	assign cls_p     = char_class(prev_q);
	assign cbh_next  = cbh_q + 8'd1;

	// Classify the character into a command word
	always_comb begin
		q_data              = '0;
		q_data.rng_lo       = CHAR_HYPHEN;
		q_data.rng_hi       = CHAR_HYPHEN;
		q_data.eol          = end_of_line;
		// resolve a held hyphen against this character
		if (pend_q && cls_b != CLS_NONE) begin
			if (cls_c == cls_b && in_char > cbh_q) begin
				if (in_char != cbh_next) begin
					q_data.rng_v  = 1'b1;
					q_data.rng_lo = cbh_next;
					q_data.rng_hi = in_char - 8'd1;
				end
			end else begin
				q_data.rng_v = 1'b1;
			end
		end
		// the character itself, a trailing hyphen, or the empty marker
		if (!is_hyphen) begin
			q_data.last_v       = 1'b1;
			q_data.last_char    = in_char;
			q_data.last_present = 1'b1;
		end else if (end_of_line) begin
			if (cls_p != CLS_NONE) begin
				q_data.last_v       = 1'b1;
				q_data.last_char    = CHAR_HYPHEN;
				q_data.last_present = 1'b1;
			end else if (!q_data.rng_v) begin
				q_data.last_v       = 1'b1;
				q_data.last_char    = CHAR_NUL;
				q_data.last_present = 1'b0;
			end
		end
	end

	// Drop words that cause no result
	assign q_wr = accept && (q_data.rng_v || q_data.last_v);

	// Update line state; end of line returns to reset values
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q <= CHAR_NUL;
			pend_q <= 1'b0;
			cbh_q  <= CHAR_NUL;
		end else if (accept) begin
			if (end_of_line) begin
				prev_q <= CHAR_NUL;
				pend_q <= 1'b0;
				cbh_q  <= CHAR_NUL;
			end else begin
				prev_q <= in_char;
				pend_q <= is_hyphen;
				if (is_hyphen) begin
					cbh_q <= prev_q;
				end
			end
		end
	end

endmodule

`default_nettype wire

### rtl/cre_back.sv
// ----------------------------------------------------------------------------
// cre_back
// Carries out command words: walks character runs one result per cycle when
// not stalled by a full output register, and holds each result there until popped.
// ----------------------------------------------------------------------------
`default_nettype none

module cre_back
	import cre_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire cmd_t       q_data,
	input  wire logic       q_empty,
	output logic            q_rd,
	input  wire logic       pop,
	output logic            empty,
	output logic [7:0]      out_char,
	output logic            char_present,
	output logic            run_end,
	output logic            line_end
);

	back_phase_t phase_q;
	back_phase_t phase_d;
	cmd_t        cmd_q;
	logic [7:0]  cur_q;
	logic [7:0]  cur_d;

	logic        ov_q;
	logic [7:0]  char_q;
	logic        present_q;
	logic        run_end_q;
	logic        line_end_q;

	logic        adv;
	logic        emit;
	logic        finish;
	logic        load;
	logic        range_done;
	logic [7:0]  e_char;
	logic        e_present;
	logic        e_run;
	logic        e_line;

	assign adv        = !ov_q || pop;
	assign range_done = (cur_q == cmd_q.rng_hi);

	// Next phase and the result to emit
	always_comb begin
		phase_d   = phase_q;
		cur_d     = cur_q;
		emit      = 1'b0;
		finish    = 1'b0;
		e_char    = cur_q;
		e_present = 1'b1;
		e_run     = 1'b0;
		e_line    = 1'b0;
		unique case (phase_q)
			B_IDLE: begin
				finish = 1'b1;
			end
			B_RANGE: begin
				if (adv) begin
					emit   = 1'b1;
					e_run  = range_done && !cmd_q.last_v;
					e_line = range_done && !cmd_q.last_v && cmd_q.eol;
					if (range_done) begin
						if (cmd_q.last_v) begin
							phase_d = B_LAST;
						end else begin
							finish = 1'b1;
						end
					end else begin
						cur_d = cur_q + 8'd1;
					end
				end
			end
			B_LAST: begin
				if (adv) begin
					emit      = 1'b1;
					e_char    = cmd_q.last_char;
					e_present = cmd_q.last_present;
					e_run     = 1'b1;
					e_line    = cmd_q.eol;
					finish    = 1'b1;
				end
			end
			default: begin
				finish = 1'b1;
			end
		endcase
		load = finish && !q_empty;
		if (load) begin
			phase_d = q_data.rng_v ? B_RANGE : B_LAST;
			cur_d   = q_data.rng_lo;
		end else if (finish) begin
			phase_d = B_IDLE;
		end
	end

	assign q_rd = load;

	// Hold the sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= B_IDLE;
		end else begin
			phase_q <= phase_d;
		end
	end

	// Latch command payload and run position
	always_ff @(posedge clk) begin
		if (load) begin
			cmd_q <= q_data;
		end
		cur_q <= cur_d;
	end

	// Output register: fill on emit, drain on pop
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
		end else if (emit) begin
			ov_q <= 1'b1;
		end else if (pop) begin
			ov_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			char_q     <= e_char;
			present_q  <= e_present;
			run_end_q  <= e_run;
			line_end_q <= e_line;
		end
	end

	assign empty        = !ov_q;
	assign out_char     = char_q;
	assign char_present = present_q;
	assign run_end      = run_end_q;
	assign line_end     = line_end_q;

endmodule

`default_nettype wire

### rtl/character_range_expander.sv
// ----------------------------------------------------------------------------
// character_range_expander
// Expands shorthand character ranges such as a-e into abcde, one line at a
// time.
//
// Characters are pushed one word per cycle while full is low, and results
// are popped from a queue-style output. The block keeps a rate of one result
// per cycle while results are popped; a range a-z is walked by the back end
// one generated character at a time, so the input can see full while the
// back end walks the run (up to 25 results for one input word). The rate is
// set by the back end's run counter, which produces one result per cycle
// while its output register is free or popped; the front end classifies the
// next characters meanwhile until the command queue between the two fills.
// A hyphen is held until the following character arrives, so its results
// appear with that character's. Every line ends with a result marked
// line_end, an empty marker (char_present low) when the last input word of
// the line yields no character. There is no startup sweep.
`default_nettype none

module character_range_expander
	import cre_pkg::*;
#(
	parameter int QDEPTH = QUEUE_DEPTH
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       push,
	output logic            full,
	input  wire logic [7:0] in_char,
	input  wire logic       end_of_line,
	output logic            empty,
	input  wire logic       pop,
	output logic [7:0]      out_char,
	output logic            char_present,
	output logic            run_end,
	output logic            line_end
);

	logic q_wr;
	logic q_full;
	logic q_rd;
	logic q_empty;
	cmd_t q_wdata;
	cmd_t q_rdata;

	// Classify incoming characters
	cre_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.in_char     (in_char),
		.end_of_line (end_of_line),
		.q_full      (q_full),
		.full        (full),
		.q_wr        (q_wr),
		.q_data      (q_wdata)
	);

	// Buffer command words between the two halves
	cre_queue #(
		.DEPTH (QDEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (q_wr),
		.wr_data (q_wdata),
		.full    (q_full),
		.rd      (q_rd),
		.rd_data (q_rdata),
		.empty   (q_empty)
	);

	// Emit results
	cre_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_data       (q_rdata),
		.q_empty      (q_empty),
		.q_rd         (q_rd),
		.pop          (pop),
		.empty        (empty),
		.out_char     (out_char),
		.char_present (char_present),
		.run_end      (run_end),
		.line_end     (line_end)
	);

endmodule

`default_nettype wire

### rtl/cre_checker.sv
// ----------------------------------------------------------------------------
// cre_checker
// Port-level checks on the result side of the range expander.
// ----------------------------------------------------------------------------
`default_nettype none

`include "character_range_expander_macros.svh"

module cre_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       empty,
	input wire logic       pop,
	input wire logic [7:0] out_char,
	input wire logic       char_present,
	input wire logic       run_end,
	input wire logic       line_end
);

	// A line end is always the last result of its input word
	`CRE_ASSERT_IMPL(a_line_end_run, clk, arst_n, !empty && line_end, run_end, "line_end without run_end")

	// An empty marker only closes a line
	`CRE_ASSERT_IMPL(a_marker_at_eol, clk, arst_n, !empty && !char_present, line_end && run_end, "empty marker inside a line")

	// An empty marker carries a zero byte
	`CRE_ASSERT_IMPL(a_marker_zero, clk, arst_n, !empty && !char_present, out_char == 8'h00, "empty marker with nonzero char")

	// A waiting word holds until popped
	`CRE_ASSERT_NEXT(a_hold, clk, arst_n, !empty && !pop, !empty && $stable(out_char) && $stable(line_end), "result changed while stalled")

endmodule

bind character_range_expander cre_checker u_cre_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.empty        (empty),
	.pop          (pop),
	.out_char     (out_char),
	.char_present (char_present),
	.run_end      (run_end),
	.line_end     (line_end)
);

`default_nettype wire
